// ----- rtl/core/psd_pkg.sv -----
// Shared types and constants for the PAM stream decoder.
// Used by the controller, the datapath and the top level. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package psd_pkg;

    // result kinds
    localparam logic [1:0] KIND_HDR = 2'd0;
    localparam logic [1:0] KIND_PIX = 2'd1;
    localparam logic [1:0] KIND_ERR = 2'd2;

    // error codes
    localparam logic [2:0] ERR_MAGIC = 3'd0;
    localparam logic [2:0] ERR_KEYWORD = 3'd1;
    localparam logic [2:0] ERR_TUPLE = 3'd2;
    localparam logic [2:0] ERR_LINE = 3'd3;
    localparam logic [2:0] ERR_TRUNC = 3'd4;
    localparam logic [2:0] ERR_SIZE = 3'd5;

    // header keywords awaiting a value
    localparam logic [2:0] KW_NONE = 3'd0;
    localparam logic [2:0] KW_WIDTH = 3'd1;
    localparam logic [2:0] KW_HEIGHT = 3'd2;
    localparam logic [2:0] KW_DEPTH = 3'd3;
    localparam logic [2:0] KW_MAXVAL = 3'd4;
    localparam logic [2:0] KW_TUPL = 3'd5;

    // characters
    localparam logic [7:0] CH_P = 8'h50;
    localparam logic [7:0] CH_7 = 8'h37;
    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_HASH = 8'h23;
    localparam logic [7:0] CH_0 = 8'h30;
    localparam logic [7:0] CH_9 = 8'h39;

    // token texts, left aligned and padded to the compare span
    localparam int TOK_CMP = 9;
    localparam logic [71:0] TXT_ENDHDR = "ENDHDR   ";
    localparam logic [71:0] TXT_WIDTH = "WIDTH    ";
    localparam logic [71:0] TXT_HEIGHT = "HEIGHT   ";
    localparam logic [71:0] TXT_DEPTH = "DEPTH    ";
    localparam logic [71:0] TXT_MAXVAL = "MAXVAL   ";
    localparam logic [71:0] TXT_TUPL = "TUPLTYPE ";
    localparam logic [71:0] TXT_RGB = "RGB      ";
    localparam logic [71:0] TXT_RGBA = {"RGB", 8'h5F, "ALPHA"};
    localparam logic [3:0] LEN_ENDHDR = 4'd6;
    localparam logic [3:0] LEN_WIDTH = 4'd5;
    localparam logic [3:0] LEN_HEIGHT = 4'd6;
    localparam logic [3:0] LEN_DEPTH = 4'd5;
    localparam logic [3:0] LEN_MAXVAL = 4'd6;
    localparam logic [3:0] LEN_TUPL = 4'd8;
    localparam logic [3:0] LEN_RGB = 4'd3;
    localparam logic [3:0] LEN_RGBA = 4'd9;

    localparam logic [16:0] NUM_SAT = 17'd131071;
    localparam logic [16:0] MAXVAL_LIMIT = 17'd65535;
    localparam logic [7:0] SAMPLE_MAX = 8'd255;
    localparam logic [4:0] DIV_STEPS = 5'd17;

    typedef struct packed {
        logic       tok_start;
        logic       tok_append;
        logic       kw_set;
        logic [2:0] kw_id;
        logic       num_start;
        logic       num_digit;
        logic       num_store;
        logic       tup_set;
        logic       tup_alpha;
        logic       hdr_clear;
        logic       hdr_finish;
        logic       pix_start;
        logic       out_load;
        logic [1:0] out_kind;
        logic [2:0] out_err;
    } psd_cmd_t;

    typedef struct packed {
        logic       is_blank;
        logic       is_lf;
        logic       is_digit;
        logic       is_p;
        logic       is_7;
        logic       is_hash;
        logic       m_endhdr;
        logic       kw_hit;
        logic [2:0] kw_id;
        logic       m_rgb;
        logic       m_rgba;
        logic       tok_full;
        logic       num_bad;
        logic       hdr_ok;
        logic       pend_tupl;
        logic       last_sample;
        logic       div_done;
    } psd_stat_t;

endpackage

`default_nettype wire

// ----- rtl/core/psd_ctrl.sv -----
// Controller: parse phase and engine state machines, handshake control.
// Depends on psd_pkg; drives commands into psd_datapath and reads its status.
`timescale 1ns / 1ps
`default_nettype none

module psd_ctrl
    import psd_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_stall,
    input  wire logic      end_of_stream,
    output logic           out_valid,
    input  wire logic      out_stall,
    input  wire psd_stat_t stat,
    output psd_cmd_t       cmd
);

    localparam logic [3:0] PH_MAG_P = 4'd0;
    localparam logic [3:0] PH_MAG_7 = 4'd1;
    localparam logic [3:0] PH_MAG_NL = 4'd2;
    localparam logic [3:0] PH_LINE = 4'd3;
    localparam logic [3:0] PH_COMMENT = 4'd4;
    localparam logic [3:0] PH_KEY = 4'd5;
    localparam logic [3:0] PH_PREVAL = 4'd6;
    localparam logic [3:0] PH_NUM = 4'd7;
    localparam logic [3:0] PH_TUPLE = 4'd8;
    localparam logic [3:0] PH_TAIL = 4'd9;
    localparam logic [3:0] PH_ENDTAIL = 4'd10;
    localparam logic [3:0] PH_PIX = 4'd11;
    localparam logic [3:0] PH_DROP = 4'd12;

    localparam logic ENG_IDLE = 1'b0;
    localparam logic ENG_DIV = 1'b1;

    logic [3:0] phase_reg, phase_next;
    logic       eng_reg, eng_next;
    logic       out_valid_reg, out_valid_next;
    logic       accept, take;
    logic       res_err, res_hdr, res_pix, done, finish;
    logic [2:0] err_code;

    assign in_stall = (eng_reg != ENG_IDLE) || (out_valid_reg && out_stall);
    assign out_valid = out_valid_reg;
    assign accept = in_valid && !in_stall;
    assign take = out_valid_reg && !out_stall;

    always_comb
    begin
        cmd = '0;
        phase_next = phase_reg;
        eng_next = eng_reg;
        out_valid_next = take ? 1'b0 : out_valid_reg;
        res_err = 1'b0;
        res_hdr = 1'b0;
        res_pix = 1'b0;
        done = 1'b0;
        finish = 1'b0;
        err_code = ERR_MAGIC;

        if (accept)
        begin
            unique case (phase_reg)
                PH_MAG_P:
                begin
                    if (stat.is_p) phase_next = PH_MAG_7;
                    else res_err = 1'b1;
                end
                PH_MAG_7:
                begin
                    if (stat.is_7) phase_next = PH_MAG_NL;
                    else res_err = 1'b1;
                end
                PH_MAG_NL:
                begin
                    if (stat.is_lf)
                    begin
                        cmd.hdr_clear = 1'b1;
                        phase_next = PH_LINE;
                    end
                    else res_err = 1'b1;
                end
                PH_LINE:
                begin
                    if (stat.is_blank || stat.is_lf) phase_next = PH_LINE;
                    else if (stat.is_hash) phase_next = PH_COMMENT;
                    else
                    begin
                        cmd.tok_start = 1'b1;
                        phase_next = PH_KEY;
                    end
                end
                PH_COMMENT:
                begin
                    if (stat.is_lf) phase_next = PH_LINE;
                end
                PH_KEY:
                begin
                    if (stat.is_blank || stat.is_lf)
                    begin
                        if (stat.m_endhdr)
                        begin
                            if (stat.is_lf) finish = 1'b1;
                            else phase_next = PH_ENDTAIL;
                        end
                        else if (stat.kw_hit)
                        begin
                            cmd.kw_set = 1'b1;
                            cmd.kw_id = stat.kw_id;
                            if (stat.is_lf)
                            begin
                                res_err = 1'b1;
                                err_code = ERR_LINE;
                            end
                            else phase_next = PH_PREVAL;
                        end
                        else
                        begin
                            res_err = 1'b1;
                            err_code = ERR_KEYWORD;
                        end
                    end
                    else if (stat.tok_full)
                    begin
                        res_err = 1'b1;
                        err_code = ERR_KEYWORD;
                    end
                    else cmd.tok_append = 1'b1;
                end
                PH_PREVAL:
                begin
                    if (stat.is_blank) phase_next = PH_PREVAL;
                    else if (stat.is_lf)
                    begin
                        res_err = 1'b1;
                        err_code = ERR_LINE;
                    end
                    else if (stat.pend_tupl)
                    begin
                        cmd.tok_start = 1'b1;
                        phase_next = PH_TUPLE;
                    end
                    else if (stat.is_digit)
                    begin
                        cmd.num_start = 1'b1;
                        phase_next = PH_NUM;
                    end
                    else
                    begin
                        res_err = 1'b1;
                        err_code = ERR_LINE;
                    end
                end
                PH_NUM:
                begin
                    if (stat.is_digit) cmd.num_digit = 1'b1;
                    else if (stat.is_blank || stat.is_lf)
                    begin
                        if (stat.num_bad)
                        begin
                            res_err = 1'b1;
                            err_code = ERR_SIZE;
                        end
                        else
                        begin
                            cmd.num_store = 1'b1;
                            phase_next = stat.is_lf ? PH_LINE : PH_TAIL;
                        end
                    end
                    else
                    begin
                        res_err = 1'b1;
                        err_code = ERR_LINE;
                    end
                end
                PH_TUPLE:
                begin
                    if (stat.is_blank || stat.is_lf)
                    begin
                        if (stat.m_rgb || stat.m_rgba)
                        begin
                            cmd.tup_set = 1'b1;
                            cmd.tup_alpha = stat.m_rgba;
                            phase_next = stat.is_lf ? PH_LINE : PH_TAIL;
                        end
                        else
                        begin
                            res_err = 1'b1;
                            err_code = ERR_TUPLE;
                        end
                    end
                    else if (stat.tok_full)
                    begin
                        res_err = 1'b1;
                        err_code = ERR_TUPLE;
                    end
                    else cmd.tok_append = 1'b1;
                end
                PH_TAIL:
                begin
                    if (stat.is_lf) phase_next = PH_LINE;
                    else if (!stat.is_blank)
                    begin
                        res_err = 1'b1;
                        err_code = ERR_LINE;
                    end
                end
                PH_ENDTAIL:
                begin
                    if (stat.is_lf) finish = 1'b1;
                    else if (!stat.is_blank)
                    begin
                        res_err = 1'b1;
                        err_code = ERR_LINE;
                    end
                end
                PH_PIX:
                begin
                    cmd.pix_start = 1'b1;
                    res_pix = 1'b1;
                    if (stat.last_sample)
                    begin
                        done = 1'b1;
                        phase_next = PH_MAG_P;
                    end
                end
                default:
                begin
                    phase_next = PH_DROP;
                end
            endcase

            if (finish)
            begin
                if (stat.hdr_ok)
                begin
                    cmd.hdr_finish = 1'b1;
                    res_hdr = 1'b1;
                    phase_next = PH_PIX;
                end
                else
                begin
                    res_err = 1'b1;
                    err_code = ERR_SIZE;
                end
            end

            if (res_err) phase_next = PH_DROP;

            // an unfinished image at end of stream overrides a header or sample
            if (end_of_stream)
            begin
                if (phase_next != PH_DROP && !done)
                begin
                    res_err = 1'b1;
                    err_code = ERR_TRUNC;
                    res_hdr = 1'b0;
                    res_pix = 1'b0;
                end
                phase_next = PH_MAG_P;
            end

            if (res_err || res_hdr)
            begin
                cmd.out_load = 1'b1;
                cmd.out_kind = res_err ? KIND_ERR : KIND_HDR;
                cmd.out_err = err_code;
                out_valid_next = 1'b1;
            end
            if (res_pix) eng_next = ENG_DIV;
        end

        // hand the divided sample to the output register once it is free
        if (eng_reg == ENG_DIV && stat.div_done && (!out_valid_reg || take))
        begin
            cmd.out_load = 1'b1;
            cmd.out_kind = KIND_PIX;
            out_valid_next = 1'b1;
            eng_next = ENG_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_MAG_P;
            eng_reg <= ENG_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            eng_reg <= eng_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/psd_datapath.sv -----
// Datapath: token store, number accumulator, header registers, sample
// counters, restoring divider and output register. Depends on psd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module psd_datapath
    import psd_pkg::*;
#(
    parameter int MAX_SIDE = 4096,
    parameter int MAX_TOKEN_LEN = 9
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic [7:0] data_byte,
    input  wire psd_cmd_t cmd,
    output psd_stat_t     stat,
    output logic [1:0]    result_kind,
    output logic [12:0]   image_width,
    output logic [12:0]   image_height,
    output logic          has_alpha,
    output logic [15:0]   max_sample,
    output logic [7:0]    sample,
    output logic [1:0]    channel,
    output logic          last_of_pixel,
    output logic          last_of_image,
    output logic [2:0]    error_code
);

    localparam int SIDE_W = $clog2(MAX_SIDE + 1);
    localparam int PX_W = 2 * SIDE_W;
    localparam int SL_W = PX_W + 2;
    localparam int TL_W = $clog2(MAX_TOKEN_LEN + 1);
    localparam int IDX_W = $clog2(MAX_TOKEN_LEN);

    logic [7:0]        tok_mem [MAX_TOKEN_LEN];
    logic [TOK_CMP-1:0][7:0] tok_view;
    logic [TL_W-1:0]   tok_len_reg;
    logic [2:0]        pend_reg;
    logic [16:0]       acc_reg;
    logic [SIDE_W-1:0] width_reg, height_reg;
    logic [15:0]       maxval_reg;
    logic              alpha_reg;
    logic [PX_W-1:0]   pix_reg;
    logic [SL_W-1:0]   left_reg;
    logic [1:0]        chan_reg;

    logic [15:0]       div_rem_reg;
    logic [16:0]       div_num_reg, div_quo_reg;
    logic [4:0]        div_cnt_reg;
    logic [1:0]        pend_chan_reg;
    logic              pend_lastpix_reg, pend_lastimg_reg;

    logic [1:0]  kind_reg;
    logic [12:0] ow_reg, oh_reg;
    logic        oa_reg;
    logic [15:0] om_reg;
    logic [7:0]  os_reg;
    logic [1:0]  oc_reg;
    logic        olp_reg, oli_reg;
    logic [2:0]  oe_reg;

    logic [3:0]  digit;
    logic [20:0] acc_ext, acc_prod;
    logic [16:0] acc_next;
    logic        lastpix;
    logic [16:0] div_trial;
    logic [16:0] numer;
    logic [7:0]  sat_q;

    function automatic logic tok_eq(input logic [71:0] txt, input logic [3:0] n,
                                    input logic [TL_W-1:0] len,
                                    input logic [TOK_CMP-1:0][7:0] chars);
        logic ok;
        ok = (len == TL_W'(n));
        for (int i = 0; i < TOK_CMP; i++)
        begin
            if (4'(i) < n && chars[i] != txt[71 - 8 * i -: 8]) ok = 1'b0;
        end
        return ok;
    endfunction

    always_comb
    begin
        for (int i = 0; i < TOK_CMP; i++) tok_view[i] = tok_mem[i];
    end

    assign digit = data_byte[3:0];
    assign acc_ext = {4'b0, acc_reg};
    assign acc_prod = (acc_ext << 3) + (acc_ext << 1) + {17'b0, digit};
    assign acc_next = (acc_prod > 21'(NUM_SAT)) ? NUM_SAT : acc_prod[16:0];
    assign lastpix = (chan_reg == (alpha_reg ? 2'd3 : 2'd2));
    assign div_trial = {div_rem_reg, div_num_reg[16]};
    assign numer = {1'b0, data_byte, 8'b0} - {9'b0, data_byte} + {2'b0, maxval_reg[15:1]};
    assign sat_q = (|div_quo_reg[16:8]) ? SAMPLE_MAX : div_quo_reg[7:0];

    always_comb
    begin
        stat = '0;
        stat.is_blank = (data_byte == CH_SPACE) || (data_byte == CH_TAB) ||
                        (data_byte == CH_CR);
        stat.is_lf = (data_byte == CH_LF);
        stat.is_digit = (data_byte >= CH_0) && (data_byte <= CH_9);
        stat.is_p = (data_byte == CH_P);
        stat.is_7 = (data_byte == CH_7);
        stat.is_hash = (data_byte == CH_HASH);
        stat.m_endhdr = tok_eq(TXT_ENDHDR, LEN_ENDHDR, tok_len_reg, tok_view);
        stat.kw_hit = 1'b1;
        if (tok_eq(TXT_WIDTH, LEN_WIDTH, tok_len_reg, tok_view)) stat.kw_id = KW_WIDTH;
        else if (tok_eq(TXT_HEIGHT, LEN_HEIGHT, tok_len_reg, tok_view))
            stat.kw_id = KW_HEIGHT;
        else if (tok_eq(TXT_DEPTH, LEN_DEPTH, tok_len_reg, tok_view)) stat.kw_id = KW_DEPTH;
        else if (tok_eq(TXT_MAXVAL, LEN_MAXVAL, tok_len_reg, tok_view))
            stat.kw_id = KW_MAXVAL;
        else if (tok_eq(TXT_TUPL, LEN_TUPL, tok_len_reg, tok_view)) stat.kw_id = KW_TUPL;
        else
        begin
            stat.kw_hit = 1'b0;
            stat.kw_id = KW_NONE;
        end
        stat.m_rgb = tok_eq(TXT_RGB, LEN_RGB, tok_len_reg, tok_view);
        stat.m_rgba = tok_eq(TXT_RGBA, LEN_RGBA, tok_len_reg, tok_view);
        stat.tok_full = (tok_len_reg >= TL_W'(MAX_TOKEN_LEN));
        case (pend_reg) inside
            KW_WIDTH, KW_HEIGHT: stat.num_bad = (acc_reg == '0) || (acc_reg > 17'(MAX_SIDE));
            KW_MAXVAL: stat.num_bad = (acc_reg == '0) || (acc_reg > MAXVAL_LIMIT);
            default: stat.num_bad = 1'b0;
        endcase
        stat.hdr_ok = (width_reg != '0) && (height_reg != '0) && (maxval_reg != '0);
        stat.pend_tupl = (pend_reg == KW_TUPL);
        stat.last_sample = (left_reg == SL_W'(1));
        stat.div_done = (div_cnt_reg == '0);
    end

    // token store: no reset, entries are read only below the fill length
    always_ff @(posedge clk)
    begin
        if (cmd.tok_start) tok_mem[0] <= data_byte;
        else if (cmd.tok_append) tok_mem[tok_len_reg[IDX_W-1:0]] <= data_byte;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_len_reg <= '0;
            pend_reg <= KW_NONE;
            acc_reg <= '0;
            width_reg <= '0;
            height_reg <= '0;
            maxval_reg <= '0;
            alpha_reg <= 1'b0;
            pix_reg <= '0;
            left_reg <= '0;
            chan_reg <= '0;
            div_cnt_reg <= '0;
        end
        else
        begin
            pix_reg <= PX_W'(width_reg * height_reg);
            if (cmd.hdr_clear)
            begin
                tok_len_reg <= '0;
                pend_reg <= KW_NONE;
                acc_reg <= '0;
                width_reg <= '0;
                height_reg <= '0;
                maxval_reg <= '0;
                alpha_reg <= 1'b0;
            end
            if (cmd.tok_start) tok_len_reg <= TL_W'(1);
            else if (cmd.tok_append) tok_len_reg <= tok_len_reg + TL_W'(1);
            if (cmd.kw_set) pend_reg <= cmd.kw_id;
            if (cmd.num_start) acc_reg <= {13'b0, digit};
            else if (cmd.num_digit) acc_reg <= acc_next;
            if (cmd.num_store)
            begin
                case (pend_reg)
                    KW_WIDTH: width_reg <= acc_reg[SIDE_W-1:0];
                    KW_HEIGHT: height_reg <= acc_reg[SIDE_W-1:0];
                    KW_MAXVAL: maxval_reg <= acc_reg[15:0];
                    default: ;
                endcase
            end
            if (cmd.tup_set) alpha_reg <= cmd.tup_alpha;
            if (cmd.hdr_finish)
            begin
                left_reg <= alpha_reg ? {pix_reg, 2'b00}
                                      : {2'b00, pix_reg} + {1'b0, pix_reg, 1'b0};
                chan_reg <= '0;
            end
            if (cmd.pix_start)
            begin
                chan_reg <= lastpix ? 2'd0 : chan_reg + 2'd1;
                left_reg <= left_reg - SL_W'(1);
                div_cnt_reg <= DIV_STEPS;
            end
            else if (div_cnt_reg != '0)
            begin
                div_cnt_reg <= div_cnt_reg - 5'd1;
            end
        end
    end

    // restoring divider, one quotient bit per cycle
    always_ff @(posedge clk)
    begin
        if (cmd.pix_start)
        begin
            div_num_reg <= numer;
            div_rem_reg <= '0;
            div_quo_reg <= '0;
            pend_chan_reg <= chan_reg;
            pend_lastpix_reg <= lastpix;
            pend_lastimg_reg <= (left_reg == SL_W'(1));
        end
        else if (div_cnt_reg != '0)
        begin
            div_num_reg <= {div_num_reg[15:0], 1'b0};
            if (div_trial >= {1'b0, maxval_reg})
            begin
                div_rem_reg <= 16'(div_trial - {1'b0, maxval_reg});
                div_quo_reg <= {div_quo_reg[15:0], 1'b1};
            end
            else
            begin
                div_rem_reg <= div_trial[15:0];
                div_quo_reg <= {div_quo_reg[15:0], 1'b0};
            end
        end
    end

    // output register: fields that do not belong to the result kind read zero
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            kind_reg <= cmd.out_kind;
            case (cmd.out_kind)
                KIND_HDR:
                begin
                    ow_reg <= 13'(width_reg);
                    oh_reg <= 13'(height_reg);
                    oa_reg <= alpha_reg;
                    om_reg <= maxval_reg;
                    os_reg <= '0;
                    oc_reg <= '0;
                    olp_reg <= 1'b0;
                    oli_reg <= 1'b0;
                    oe_reg <= '0;
                end
                KIND_PIX:
                begin
                    ow_reg <= '0;
                    oh_reg <= '0;
                    oa_reg <= 1'b0;
                    om_reg <= '0;
                    os_reg <= sat_q;
                    oc_reg <= pend_chan_reg;
                    olp_reg <= pend_lastpix_reg;
                    oli_reg <= pend_lastimg_reg;
                    oe_reg <= '0;
                end
                default:
                begin
                    ow_reg <= '0;
                    oh_reg <= '0;
                    oa_reg <= 1'b0;
                    om_reg <= '0;
                    os_reg <= '0;
                    oc_reg <= '0;
                    olp_reg <= 1'b0;
                    oli_reg <= 1'b0;
                    oe_reg <= cmd.out_err;
                end
            endcase
        end
    end

    assign result_kind = kind_reg;
    assign image_width = ow_reg;
    assign image_height = oh_reg;
    assign has_alpha = oa_reg;
    assign max_sample = om_reg;
    assign sample = os_reg;
    assign channel = oc_reg;
    assign last_of_pixel = olp_reg;
    assign last_of_image = oli_reg;
    assign error_code = oe_reg;

endmodule

`default_nettype wire

// ----- rtl/core/pam_stream_decoder_core.sv -----
// Header bytes: result (header or error) in the cycle after the input transfer;
//   a byte that gives no result frees the input for the next cycle.
// Sample bytes: scaled by the 17-step restoring divider by MAXVAL; the input
//   stays stalled until the sample is loaded into the output register.
// Reset (rst_n low, asynchronous): awaits the magic line, header cleared,
//   output empty. No clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module pam_stream_decoder_core
    import psd_pkg::*;
#(
    parameter int MAX_SIDE = 4096,
    parameter int MAX_TOKEN_LEN = 9
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] data_byte,
    input  wire logic       end_of_stream,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [1:0]      result_kind,
    output logic [12:0]     image_width,
    output logic [12:0]     image_height,
    output logic            has_alpha,
    output logic [15:0]     max_sample,
    output logic [7:0]      sample,
    output logic [1:0]      channel,
    output logic            last_of_pixel,
    output logic            last_of_image,
    output logic [2:0]      error_code
);

    psd_cmd_t  cmd;
    psd_stat_t stat;

    psd_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .end_of_stream (end_of_stream),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .stat          (stat),
        .cmd           (cmd)
    );

    psd_datapath #(
        .MAX_SIDE      (MAX_SIDE),
        .MAX_TOKEN_LEN (MAX_TOKEN_LEN)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .data_byte     (data_byte),
        .cmd           (cmd),
        .stat          (stat),
        .result_kind   (result_kind),
        .image_width   (image_width),
        .image_height  (image_height),
        .has_alpha     (has_alpha),
        .max_sample    (max_sample),
        .sample        (sample),
        .channel       (channel),
        .last_of_pixel (last_of_pixel),
        .last_of_image (last_of_image),
        .error_code    (error_code)
    );

endmodule

`default_nettype wire

// ----- rtl/core/psd_checker.sv -----
// Port-level checks for pam_stream_decoder_core, attached by bind.
// Depends on psd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module psd_checker
    import psd_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_stall,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [1:0]  result_kind,
    input wire logic [7:0]  sample,
    input wire logic [1:0]  channel,
    input wire logic        has_alpha,
    input wire logic        last_of_pixel,
    input wire logic        last_of_image,
    input wire logic [2:0]  error_code
);

    // a held result keeps its content
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(result_kind) && $stable(sample))
        else $error("stalled result changed");

    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (result_kind == KIND_HDR || result_kind == KIND_PIX ||
                       result_kind == KIND_ERR))
        else $error("bad result kind");

    // last sample of an image is always the last channel of its pixel
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_kind == KIND_PIX && (last_of_image || channel == 2'd3)
        |-> last_of_pixel && !has_alpha)
        else $error("last sample not at pixel end");

    a_err: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_kind == KIND_ERR |-> error_code <= ERR_SIZE && sample == '0)
        else $error("bad error result");

    // a stalled output blocks the input
    a_block: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |-> in_stall || !in_valid)
        else $error("input taken while output blocked");

endmodule

bind pam_stream_decoder_core psd_checker u_psd_checker (.*);

`default_nettype wire

// ----- bench/pam_stream_decoder_checker.sv -----
// Checker for the PAM stream decoder: watches both channels, predicts every result
// from the accepted bytes and compares it field by field. Depends on psd_pkg.
`timescale 1ns / 1ps

module pam_stream_decoder_checker
    import psd_pkg::*;
#(
    parameter int MAX_SIDE = 4096,
    parameter int MAX_TOKEN_LEN = 9
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        end_of_stream,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [1:0]  result_kind,
    input  logic [12:0] image_width,
    input  logic [12:0] image_height,
    input  logic        has_alpha,
    input  logic [15:0] max_sample,
    input  logic [7:0]  sample,
    input  logic [1:0]  channel,
    input  logic        last_of_pixel,
    input  logic        last_of_image,
    input  logic [2:0]  error_code,
    output int          failures,
    output int          waiting,
    output int          headers_seen,
    output int          samples_seen,
    output int          errors_seen
);

    localparam string ALPHA_TUPLE = {"RGB", "_", "ALPHA"};

    typedef struct packed {
        logic [1:0]  kind;
        logic [12:0] w;
        logic [12:0] h;
        logic        alpha;
        logic [15:0] maxv;
        logic [7:0]  smp;
        logic [1:0]  chan;
        logic        lpix;
        logic        limg;
        logic [2:0]  err;
    } decode_res_t;

    typedef enum {
        P_MAG_P, P_MAG_7, P_MAG_NL, P_LINE, P_COMMENT, P_KEY, P_PREVAL,
        P_NUM, P_TUPLE, P_TAIL, P_ENDTAIL, P_PIX, P_DROP
    } parse_phase_t;

    parse_phase_t ph;
    logic [7:0]   tok [MAX_TOKEN_LEN];
    int unsigned  tok_len;
    logic [2:0]   pend_kw;
    int unsigned  acc;
    int unsigned  w_reg, h_reg, d_reg, mv_reg;
    bit           alpha_reg;
    longint unsigned left_cnt;
    int unsigned  chan_cnt;

    decode_res_t  expected_results[$];

    function bit tok_is(string t);
        int i;
        if (t.len() != tok_len)
            return 0;
        for (i = 0; i < t.len(); i++)
            if (tok[i] != t[i])
                return 0;
        return 1;
    endfunction

    function decode_res_t fail(logic [2:0] code);
        decode_res_t r;
        r = '0;
        r.kind = KIND_ERR;
        r.err = code;
        ph = P_DROP;
        return r;
    endfunction

    function decode_res_t close_header();
        decode_res_t r;
        r = '0;
        if (w_reg == 0 || h_reg == 0 || mv_reg == 0)
            return fail(ERR_SIZE);
        r.kind = KIND_HDR;
        r.w = w_reg[12:0];
        r.h = h_reg[12:0];
        r.alpha = alpha_reg;
        r.maxv = mv_reg[15:0];
        left_cnt = longint'(w_reg) * h_reg * (alpha_reg ? 4 : 3);
        chan_cnt = 0;
        ph = P_PIX;
        return r;
    endfunction

    task decode_byte(input logic [7:0] c, input logic eos, output bit got,
                     output decode_res_t r);
        bit done, blank, lf, dig, bad, lastpix;
        int unsigned m, s, d, chans;
        got = 0;
        r = '0;
        done = 0;
        blank = (c == CH_SPACE || c == CH_TAB || c == CH_CR);
        lf = (c == CH_LF);
        dig = (c >= CH_0 && c <= CH_9);
        case (ph)
            P_MAG_P:
                if (c != CH_P) begin r = fail(ERR_MAGIC); got = 1; end
                else ph = P_MAG_7;
            P_MAG_7:
                if (c != CH_7) begin r = fail(ERR_MAGIC); got = 1; end
                else ph = P_MAG_NL;
            P_MAG_NL:
                if (!lf) begin
                    r = fail(ERR_MAGIC);
                    got = 1;
                end else begin
                    w_reg = 0; h_reg = 0; d_reg = 0; mv_reg = 0;
                    alpha_reg = 0; pend_kw = KW_NONE; tok_len = 0; acc = 0;
                    ph = P_LINE;
                end
            P_LINE:
                if (c == CH_HASH) ph = P_COMMENT;
                else if (!blank && !lf) begin
                    tok[0] = c; tok_len = 1; ph = P_KEY;
                end
            P_COMMENT:
                if (lf) ph = P_LINE;
            P_KEY:
                if (blank || lf) begin
                    if (tok_is("ENDHDR")) begin
                        if (lf) begin r = close_header(); got = 1; end
                        else ph = P_ENDTAIL;
                    end else begin
                        if (tok_is("WIDTH")) pend_kw = KW_WIDTH;
                        else if (tok_is("HEIGHT")) pend_kw = KW_HEIGHT;
                        else if (tok_is("DEPTH")) pend_kw = KW_DEPTH;
                        else if (tok_is("MAXVAL")) pend_kw = KW_MAXVAL;
                        else if (tok_is("TUPLTYPE")) pend_kw = KW_TUPL;
                        else begin r = fail(ERR_KEYWORD); got = 1; end
                        if (!got) begin
                            if (lf) begin r = fail(ERR_LINE); got = 1; end
                            else ph = P_PREVAL;
                        end
                    end
                end else if (tok_len >= MAX_TOKEN_LEN) begin
                    r = fail(ERR_KEYWORD); got = 1;
                end else begin
                    tok[tok_len] = c; tok_len++;
                end
            P_PREVAL:
                if (lf) begin r = fail(ERR_LINE); got = 1; end
                else if (!blank) begin
                    if (pend_kw == KW_TUPL) begin
                        tok[0] = c; tok_len = 1; ph = P_TUPLE;
                    end else if (!dig) begin
                        r = fail(ERR_LINE); got = 1;
                    end else begin
                        acc = c - CH_0; ph = P_NUM;
                    end
                end
            P_NUM:
                if (dig) begin
                    d = c - CH_0;
                    if (acc > (NUM_SAT - d) / 10) acc = NUM_SAT;
                    else acc = acc * 10 + d;
                end else if (blank || lf) begin
                    bad = 0;
                    case (pend_kw)
                        KW_WIDTH:
                            if (acc == 0 || acc > MAX_SIDE) bad = 1; else w_reg = acc;
                        KW_HEIGHT:
                            if (acc == 0 || acc > MAX_SIDE) bad = 1; else h_reg = acc;
                        KW_MAXVAL:
                            if (acc == 0 || acc > MAXVAL_LIMIT) bad = 1; else mv_reg = acc;
                        default:
                            d_reg = (acc > 255) ? 255 : acc;
                    endcase
                    if (bad) begin r = fail(ERR_SIZE); got = 1; end
                    else ph = lf ? P_LINE : P_TAIL;
                end else begin
                    r = fail(ERR_LINE); got = 1;
                end
            P_TUPLE:
                if (blank || lf) begin
                    if (tok_is("RGB")) alpha_reg = 0;
                    else if (tok_is(ALPHA_TUPLE)) alpha_reg = 1;
                    else begin r = fail(ERR_TUPLE); got = 1; end
                    if (!got) ph = lf ? P_LINE : P_TAIL;
                end else if (tok_len >= MAX_TOKEN_LEN) begin
                    r = fail(ERR_TUPLE); got = 1;
                end else begin
                    tok[tok_len] = c; tok_len++;
                end
            P_TAIL:
                if (lf) ph = P_LINE;
                else if (!blank) begin r = fail(ERR_LINE); got = 1; end
            P_ENDTAIL:
                if (lf) begin r = close_header(); got = 1; end
                else if (!blank) begin r = fail(ERR_LINE); got = 1; end
            P_PIX: begin
                m = (mv_reg != 0) ? mv_reg : 1;
                s = (c * 255 + m / 2) / m;
                chans = alpha_reg ? 4 : 3;
                lastpix = (chan_cnt + 1 >= chans);
                r.kind = KIND_PIX;
                r.smp = (s > 255) ? SAMPLE_MAX : s[7:0];
                r.chan = chan_cnt[1:0];
                r.lpix = lastpix;
                r.limg = (left_cnt == 1);
                got = 1;
                chan_cnt = lastpix ? 0 : chan_cnt + 1;
                if (left_cnt > 0) left_cnt--;
                if (left_cnt == 0) begin
                    ph = P_MAG_P;
                    done = 1;
                end
            end
            default:
                ph = P_DROP;
        endcase
        if (eos) begin
            if (ph != P_DROP && !done) begin
                r = fail(ERR_TRUNC);
                got = 1;
            end
            ph = P_MAG_P;
        end
    endtask

    decode_res_t seen, want, pred;
    bit          pred_got;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph = P_MAG_P;
            tok_len = 0; pend_kw = KW_NONE; acc = 0;
            w_reg = 0; h_reg = 0; d_reg = 0; mv_reg = 0;
            alpha_reg = 0; left_cnt = 0; chan_cnt = 0;
            expected_results.delete();
            waiting = 0;
            failures = 0;
            headers_seen = 0; samples_seen = 0; errors_seen = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                seen = {result_kind, image_width, image_height, has_alpha, max_sample,
                        sample, channel, last_of_pixel, last_of_image, error_code};
                if (expected_results.size() == 0)
                begin
                    failures++;
                    if (failures <= 10)
                        $display("unexpected result: kind %0d err %0d sample %0d",
                                 result_kind, error_code, sample);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (seen !== want)
                    begin
                        failures++;
                        if (failures <= 10)
                        begin
                            $display("mismatch: exp kind %0d w %0d h %0d a %0d mv %0d",
                                     want.kind, want.w, want.h, want.alpha, want.maxv);
                            $display("   smp %0d ch %0d lp %0d li %0d err %0d",
                                     want.smp, want.chan, want.lpix, want.limg, want.err);
                            $display("  got kind %0d w %0d h %0d a %0d mv %0d",
                                     seen.kind, seen.w, seen.h, seen.alpha, seen.maxv);
                            $display("   smp %0d ch %0d lp %0d li %0d err %0d",
                                     seen.smp, seen.chan, seen.lpix, seen.limg, seen.err);
                        end
                    end
                end
                if (result_kind == KIND_HDR) headers_seen++;
                else if (result_kind == KIND_PIX) samples_seen++;
                else errors_seen++;
            end
            if (in_valid && !in_stall)
            begin
                decode_byte(data_byte, end_of_stream, pred_got, pred);
                if (pred_got)
                    expected_results.push_back(pred);
            end
            waiting = expected_results.size();
        end
    end

endmodule

// ----- bench/pam_stream_decoder_core_test.sv -----
// Top of the PAM stream decoder bench: clock, reset, byte-stream stimulus and the verdict.
// Depends on psd_pkg, pam_stream_decoder_core and pam_stream_decoder_checker.
`timescale 1ns / 1ps

module pam_stream_decoder_core_test;
    import psd_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int TARGET_BYTES = 600;
    localparam string ALPHA_TUPLE = {"RGB", "_", "ALPHA"};

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  data_byte;
    logic        end_of_stream;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  result_kind;
    logic [12:0] image_width;
    logic [12:0] image_height;
    logic        has_alpha;
    logic [15:0] max_sample;
    logic [7:0]  sample;
    logic [1:0]  channel;
    logic        last_of_pixel;
    logic        last_of_image;
    logic [2:0]  error_code;

    int failures, waiting, headers_seen, samples_seen, errors_seen;
    int cycles;
    int bytes_sent;
    int out_hold;
    bit calm;
    byte unsigned file_bytes[$];

    pam_stream_decoder_core dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .data_byte(data_byte), .end_of_stream(end_of_stream),
        .out_valid(out_valid), .out_stall(out_stall),
        .result_kind(result_kind), .image_width(image_width),
        .image_height(image_height), .has_alpha(has_alpha),
        .max_sample(max_sample), .sample(sample), .channel(channel),
        .last_of_pixel(last_of_pixel), .last_of_image(last_of_image),
        .error_code(error_code)
    );

    pam_stream_decoder_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .data_byte(data_byte), .end_of_stream(end_of_stream),
        .out_valid(out_valid), .out_stall(out_stall),
        .result_kind(result_kind), .image_width(image_width),
        .image_height(image_height), .has_alpha(has_alpha),
        .max_sample(max_sample), .sample(sample), .channel(channel),
        .last_of_pixel(last_of_pixel), .last_of_image(last_of_image),
        .error_code(error_code),
        .failures(failures), .waiting(waiting),
        .headers_seen(headers_seen), .samples_seen(samples_seen),
        .errors_seen(errors_seen)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // draw a fresh stall length after every result transfer
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                out_hold = calm ? 0 : $urandom_range(0, 12);
            else if (out_hold > 0)
                out_hold--;
            out_stall <= (out_hold > 0);
        end
    end

    task send_byte(input byte unsigned b, input bit eos);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 12);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        data_byte <= b;
        end_of_stream <= eos;
        do
            @(posedge clk);
        while (in_stall);
        bytes_sent++;
    endtask

    // send the buffered file, marking the last byte as end of stream
    task send_file();
        int i;
        for (i = 0; i < file_bytes.size(); i++)
            send_byte(file_bytes[i], i == file_bytes.size() - 1);
        file_bytes.delete();
    endtask

    task put_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            file_bytes.push_back(s[i]);
    endtask

    function string blanks();
        case ($urandom_range(0, 5))
            0: return " ";
            1: return "\t";
            2: return "\r";
            3: return " \t ";
            default: return "";
        endcase
    endfunction

    function string sep();
        string s;
        s = blanks();
        return (s == "") ? " " : s;
    endfunction

    // header in random line order, then random samples biased toward the extremes
    task build_image(input int w, input int h, input bit alpha, input int mv,
                     input int nsamp);
        string lines[6];
        string t;
        int n, i, j, v;
        n = 0;
        lines[n] = {blanks(), "WIDTH", sep(), $sformatf("%0d", w), blanks(), "\n"};
        n++;
        lines[n] = {blanks(), "HEIGHT", sep(), $sformatf("%0d", h), blanks(), "\n"};
        n++;
        lines[n] = {"MAXVAL", sep(), $sformatf("%0d", mv), "\n"};
        n++;
        if ($urandom_range(0, 1))
        begin
            lines[n] = {"DEPTH", sep(), $sformatf("%0d", $urandom_range(0, 400)), "\n"};
            n++;
        end
        if (alpha || $urandom_range(0, 1))
        begin
            lines[n] = {"TUPLTYPE", sep(), alpha ? ALPHA_TUPLE : "RGB", blanks(), "\n"};
            n++;
        end
        if ($urandom_range(0, 2) == 0)
        begin
            lines[n] = {blanks(), "# note ", sep(), "x\n"};
            n++;
        end
        for (i = n - 1; i > 0; i--)
        begin
            j = $urandom_range(0, i);
            t = lines[i]; lines[i] = lines[j]; lines[j] = t;
        end
        put_text("P7\n");
        for (i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 4) == 0)
                put_text("\n");
            put_text(lines[i]);
        end
        put_text($urandom_range(0, 3) == 0 ? {"ENDHDR", sep(), "\n"} : "ENDHDR\n");
        for (i = 0; i < nsamp; i++)
        begin
            case ($urandom_range(0, 5))
                0: v = 0;
                1: v = 255;
                2: v = mv & 8'hFF;
                default: v = $urandom_range(0, 255);
            endcase
            file_bytes.push_back(8'(v));
        end
    endtask

    int kind, w, h, mv, imgs, k, cut;
    bit alpha;

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        data_byte = 8'h00;
        end_of_stream = 1'b0;
        out_stall = 1'b0;
        cycles = 0;
        bytes_sent = 0;
        out_hold = 0;
        calm = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, comments, blanks and every error path
        calm = 1;
        put_text("P7\n\n # c\nWIDTH 1\nHEIGHT\t1\r\nMAXVAL 1\nDEPTH 999\nENDHDR\n");
        file_bytes.push_back(8'h00); file_bytes.push_back(8'h01);
        file_bytes.push_back(8'hFF);
        send_file();
        put_text({"P7\nTUPLTYPE ", ALPHA_TUPLE,
                  "\nWIDTH 1 \nHEIGHT 1\nMAXVAL 65535\nENDHDR \n"});
        file_bytes.push_back(8'hFF); file_bytes.push_back(8'h80);
        file_bytes.push_back(8'h00); file_bytes.push_back(8'h7F);
        send_file();
        calm = 0;
        put_text("Q"); send_file();
        put_text("P8zz"); send_file();
        put_text("P7x"); send_file();
        put_text("P7\nFOO 1\n"); send_file();
        put_text("P7\nABCDEFGHIJK 1\n"); send_file();
        put_text("P7\nTUPLTYPE GRAY\n"); send_file();
        put_text({"P7\nTUPLTYPE ", ALPHA_TUPLE, "X\n"}); send_file();
        put_text("P7\nWIDTH\n"); send_file();
        put_text("P7\nWIDTH \n"); send_file();
        put_text("P7\nWIDTH x\n"); send_file();
        put_text("P7\nWIDTH 1a\n"); send_file();
        put_text("P7\nWIDTH 3 junk\n"); send_file();
        put_text("P7\nENDHDR x\n"); send_file();
        put_text("P7\nWIDTH 0\n"); send_file();
        put_text("P7\nHEIGHT 4097\n"); send_file();
        put_text("P7\nMAXVAL 9999999\n"); send_file();
        put_text("P7\nMAXVAL 0\n"); send_file();
        put_text("P7\nWIDTH 2\nMAXVAL 5\nENDHDR\n"); send_file();
        put_text("P7\nW#D 2\n"); send_file();
        put_text("P7\nWIDTH 4096\nHEIGHT 4096\nMAXVAL 7\nENDHDR\n");
        file_bytes.push_back(8'h05); file_bytes.push_back(8'h09);
        send_file();
        put_text("P7\nWIDTH 1\nHEIGHT 1\nMAXVAL 255\nENDHDR\n"); send_file();

        // random: mostly well-formed streams, some broken or cut short, some noise
        while (bytes_sent < TARGET_BYTES)
        begin
            calm = ($urandom_range(0, 5) == 0);
            kind = $urandom_range(0, 9);
            if (kind < 8)
            begin
                imgs = $urandom_range(1, 3);
                for (k = 0; k < imgs; k++)
                begin
                    w = $urandom_range(1, 3);
                    h = $urandom_range(1, 2);
                    alpha = $urandom_range(0, 1);
                    case ($urandom_range(0, 5))
                        0: mv = 1;
                        1: mv = 255;
                        2: mv = 65535;
                        3: mv = $urandom_range(0, 20);
                        default: mv = $urandom_range(1, 65535);
                    endcase
                    if ($urandom_range(0, 15) == 0)
                    begin
                        w = $urandom_range(1, 4200);
                        h = 4096;
                    end
                    build_image(w, h, alpha, mv, (w * h <= 6) ? w * h * (alpha ? 4 : 3) : 5);
                end
                if (kind >= 6 && file_bytes.size() > 1)
                begin
                    cut = $urandom_range(0, file_bytes.size() - 1);
                    if (kind == 6)
                        file_bytes[cut] = 8'($urandom_range(0, 255));
                    else
                        while (file_bytes.size() > cut + 1)
                            void'(file_bytes.pop_back());
                end
            end
            else
            begin
                if (kind == 8)
                    put_text("P7\n");
                for (k = $urandom_range(1, 12); k > 0; k--)
                    file_bytes.push_back(8'($urandom_range(0, 255)));
            end
            send_file();
        end
        in_valid <= 1'b0;
        end_of_stream <= 1'b0;

        while (waiting != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        $display("sent %0d bytes; checked %0d headers, %0d samples, %0d errors",
                 bytes_sent, headers_seen, samples_seen, errors_seen);
        if (failures == 0 && waiting == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
